[hdl/div64_pkg.sv]
// ----------------------------------------------------------------------------
// div64_pkg
// Shared constants and types for the 64-bit signed/unsigned divider.
// ----------------------------------------------------------------------------
package div64_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int PORT_W     = 64;
  localparam int KIND_W     = 2;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [PORT_W-1:0]     port_word_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_UQUOT = 2'd0,
    KIND_UREM  = 2'd1,
    KIND_SQUOT = 2'd2,
    KIND_SREM  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIX  = 3'b100
  } state_t;

endpackage

[hdl/divider_64bit_signed_unsigned.sv]
// ----------------------------------------------------------------------------
// divider_64bit_signed_unsigned
// Radix-2 restoring divider producing an unsigned or signed quotient or
// remainder, one quotient bit per cycle.
// A request is accepted in ST_IDLE; ST_RUN produces the quotient bits, ST_FIX
// applies the sign fix-up, and the result is held in an output register.
// busy is high in ST_RUN and ST_FIX, so a new request waits until idle.
// The shared subtract-and-compare loop sets the rate; results cannot stall.
// Reset is synchronous and active low; it returns the block to idle.
// ----------------------------------------------------------------------------
module divider_64bit_signed_unsigned (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [div64_pkg::KIND_W-1:0] in_kind,
  input  div64_pkg::port_word_t      in_dividend,
  input  div64_pkg::port_word_t      in_divisor,
  output logic                       out_valid,
  output div64_pkg::port_word_t      out_result
);
  import div64_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  count_t cnt_r, cnt_nxt;

  word_t  quot_r, quot_nxt;
  word_t  rem_r, rem_nxt;
  word_t  dsr_r, dsr_nxt;
  logic   neg_r, neg_nxt;
  logic   sel_rem_r, sel_rem_nxt;
  logic   dz_r, dz_nxt;
  word_t  res_r, res_nxt;

  word_t  a_in, b_in, a_mag, b_mag, pick;
  logic   a_neg, b_neg, signed_op, accept;
  logic [DATA_WIDTH:0] rem_shift, diff;
  kind_t  kind;

  assign kind      = kind_t'(in_kind);
  assign accept    = start && (state_r == ST_IDLE);
  assign a_in      = in_dividend[DATA_WIDTH-1:0];
  assign b_in      = in_divisor[DATA_WIDTH-1:0];
  assign signed_op = (kind == KIND_SQUOT) || (kind == KIND_SREM);
  assign a_neg     = signed_op && a_in[DATA_WIDTH-1];
  assign b_neg     = signed_op && b_in[DATA_WIDTH-1];
  assign a_mag     = a_neg ? (~a_in + word_t'(1)) : a_in;
  assign b_mag     = b_neg ? (~b_in + word_t'(1)) : b_in;

  assign rem_shift = {rem_r, quot_r[DATA_WIDTH-1]};
  assign diff      = rem_shift - {1'b0, dsr_r};
  assign pick      = sel_rem_r ? rem_r : quot_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cnt_nxt       = cnt_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    neg_nxt       = neg_r;
    sel_rem_nxt   = sel_rem_r;
    dz_nxt        = dz_r;
    res_nxt       = res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          quot_nxt    = a_mag;
          rem_nxt     = '0;
          dsr_nxt     = b_mag;
          dz_nxt      = (b_in == '0);
          sel_rem_nxt = (kind == KIND_UREM) || (kind == KIND_SREM);
          case (kind)
            KIND_SQUOT: neg_nxt = a_neg ^ b_neg;
            KIND_SREM:  neg_nxt = a_neg;
            default:    neg_nxt = 1'b0;
          endcase
          cnt_nxt   = count_t'(DATA_WIDTH);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!diff[DATA_WIDTH]) begin
          rem_nxt  = diff[DATA_WIDTH-1:0];
          quot_nxt = {quot_r[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_shift[DATA_WIDTH-1:0];
          quot_nxt = {quot_r[DATA_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - count_t'(1);
        if (cnt_r == count_t'(1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (dz_r) begin
          res_nxt = '0;
        end else if (neg_r) begin
          res_nxt = ~pick + word_t'(1);
        end else begin
          res_nxt = pick;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    dsr_r     <= dsr_nxt;
    neg_r     <= neg_nxt;
    sel_rem_r <= sel_rem_nxt;
    dz_r      <= dz_nxt;
    res_r     <= res_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = port_word_t'(res_r);

endmodule

[tb/sv/divider_64bit_signed_unsigned_tb.sv]
// ----------------------------------------------------------------------------
// divider_64bit_signed_unsigned_tb
// Self-checking bench for the 64-bit signed/unsigned divider. A short table
// of directed requests covers the operand extremes, every kind, divide by
// zero, the most negative operand and the truncation and sign rules. Random
// requests follow in phases with and without sender gaps. Every result is
// compared with the quotient or remainder worked out here from the accepted
// request.
// ----------------------------------------------------------------------------
module divider_64bit_signed_unsigned_tb;
  import div64_pkg::*;

  localparam port_word_t MOST_NEG = 64'h8000_0000_0000_0000;
  localparam port_word_t MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam port_word_t ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam port_word_t MINUS_2  = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam port_word_t MINUS_3  = 64'hFFFF_FFFF_FFFF_FFFD;
  localparam port_word_t MINUS_7  = 64'hFFFF_FFFF_FFFF_FFF9;
  localparam int         RANDOM_PER_PHASE = 407;
  localparam int         NUM_VECTORS = 24;

  typedef struct {
    kind_t      kind;
    port_word_t dividend;
    port_word_t divisor;
    bit         known;
    port_word_t result;
  } vector_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [KIND_W-1:0] in_kind = '0;
  port_word_t in_dividend = '0;
  port_word_t in_divisor = '0;
  logic       out_valid;
  port_word_t out_result;

  logic       req_known = 1'b0;
  port_word_t req_result = '0;
  port_word_t pending_results[$];
  int         err_count = 0;

  vector_t vectors [0:NUM_VECTORS-1] = '{
    '{KIND_UQUOT, ALL_ONES, 64'd1, 1'b1, ALL_ONES},
    '{KIND_UREM,  ALL_ONES, 64'd1, 1'b1, 64'd0},
    '{KIND_UQUOT, 64'd0, ALL_ONES, 1'b1, 64'd0},
    '{KIND_UREM,  64'd0, ALL_ONES, 1'b1, 64'd0},
    '{KIND_UQUOT, ALL_ONES, 64'd0, 1'b1, 64'd0},
    '{KIND_UREM,  ALL_ONES, 64'd0, 1'b1, 64'd0},
    '{KIND_SQUOT, MOST_NEG, 64'd0, 1'b1, 64'd0},
    '{KIND_SREM,  MOST_NEG, 64'd0, 1'b1, 64'd0},
    '{KIND_SQUOT, MOST_NEG, ALL_ONES, 1'b1, MOST_NEG},
    '{KIND_SREM,  MOST_NEG, ALL_ONES, 1'b1, 64'd0},
    '{KIND_SQUOT, MOST_NEG, 64'd1, 1'b1, MOST_NEG},
    '{KIND_SQUOT, MINUS_7, 64'd2, 1'b1, MINUS_3},
    '{KIND_SREM,  MINUS_7, 64'd2, 1'b1, ALL_ONES},
    '{KIND_SQUOT, 64'd7, MINUS_2, 1'b1, MINUS_3},
    '{KIND_SREM,  64'd7, MINUS_2, 1'b1, 64'd1},
    '{KIND_SQUOT, MINUS_7, MINUS_2, 1'b1, 64'd3},
    '{KIND_SREM,  MINUS_7, MINUS_2, 1'b1, ALL_ONES},
    '{KIND_UQUOT, ALL_ONES, ALL_ONES, 1'b1, 64'd1},
    '{KIND_UREM,  MOST_NEG, ALL_ONES, 1'b1, MOST_NEG},
    '{KIND_SQUOT, 64'd1, MOST_NEG, 1'b1, 64'd0},
    '{KIND_SREM,  64'd1, MOST_NEG, 1'b1, 64'd1},
    '{KIND_SQUOT, MOST_NEG, MOST_NEG, 1'b1, 64'd1},
    '{KIND_SREM,  MOST_POS, MINUS_3, 1'b0, 64'd0},
    '{KIND_UQUOT, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_0001_0F0F, 1'b0, 64'd0}
  };

  divider_64bit_signed_unsigned dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_dividend(in_dividend),
    .in_divisor (in_divisor),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic port_word_t divide_words(kind_t kind, port_word_t num_in,
                                              port_word_t den_in);
    word_t num;
    word_t den;
    word_t num_mag;
    word_t den_mag;
    word_t quot;
    word_t rem;
    word_t res;
    logic  num_neg;
    logic  den_neg;
    num = num_in[DATA_WIDTH-1:0];
    den = den_in[DATA_WIDTH-1:0];
    num_neg = num[DATA_WIDTH-1];
    den_neg = den[DATA_WIDTH-1];
    if (den == '0) begin
      return '0;
    end
    if (kind == KIND_UQUOT || kind == KIND_UREM) begin
      num_mag = num;
      den_mag = den;
    end else begin
      num_mag = num_neg ? word_t'(-num) : num;
      den_mag = den_neg ? word_t'(-den) : den;
    end
    quot = num_mag / den_mag;
    rem  = num_mag % den_mag;
    case (kind)
      KIND_UQUOT: res = quot;
      KIND_UREM:  res = rem;
      KIND_SQUOT: res = (num_neg != den_neg) ? word_t'(-quot) : quot;
      default:    res = num_neg ? word_t'(-rem) : rem;
    endcase
    return port_word_t'(res);
  endfunction

  function automatic port_word_t random_operand();
    port_word_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0: v = '0;
      1: v = 64'd1;
      2: v = ALL_ONES;
      3: v = MOST_NEG;
      4: v = MOST_NEG + 64'd1;
      5: v = MOST_POS;
      default: begin
        v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result: no request outstanding, actual %h", out_result);
          err_count++;
        end else if (out_result !== pending_results[0]) begin
          $error("result: expected %h, actual %h", pending_results[0], out_result);
          err_count++;
          void'(pending_results.pop_front());
        end else begin
          void'(pending_results.pop_front());
        end
      end
      if (start && !busy) begin
        pending_results.push_back(req_known ? req_result :
                                  divide_words(kind_t'(in_kind), in_dividend, in_divisor));
      end
    end
  end

  task automatic send_request(kind_t kind, port_word_t num, port_word_t den, bit known,
                              port_word_t res, int unsigned idle_pct);
    int unsigned gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 80);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_kind     <= kind;
    in_dividend <= num;
    in_divisor  <= den;
    req_known   <= known;
    req_result  <= res;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned idle_pct [0:3];
    port_word_t  den;
    idle_pct = '{0, 77, 0, 15};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NUM_VECTORS; i++) begin
      send_request(vectors[i].kind, vectors[i].dividend, vectors[i].divisor,
                   vectors[i].known, vectors[i].result, 0);
    end
    start <= 1'b0;
    drain_results();
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        den = ($urandom_range(0, 29) == 0) ? port_word_t'(0) : random_operand();
        send_request(kind_t'($urandom_range(0, 3)), random_operand(), den, 1'b0, '0,
                     idle_pct[phase]);
      end
      start <= 1'b0;
      drain_results();
    end
    repeat (DATA_WIDTH + 10) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("divider_64bit_signed_unsigned_tb: done, clean");
    end else begin
      $display("divider_64bit_signed_unsigned_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("divider_64bit_signed_unsigned_tb: done, errors");
    $finish;
  end

endmodule

[files.f]
hdl/div64_pkg.sv
hdl/divider_64bit_signed_unsigned.sv
tb/sv/divider_64bit_signed_unsigned_tb.sv
